// File: rtl/mfd_pkg.sv
// Package for the M-Bus frame deframer: octet codes, phase encoding,
// error and frame kind codes, and the result record with its builders.
// No dependencies.
package mfd_pkg;

  localparam logic [7:0] OCT_ACK   = 8'hE5;
  localparam logic [7:0] OCT_SHORT = 8'h10;
  localparam logic [7:0] OCT_LONG  = 8'h68;
  localparam logic [7:0] OCT_STOP  = 8'h16;

  localparam logic [7:0] MIN_LENGTH   = 8'd3;
  localparam logic [7:0] SHORT_LENGTH = 8'd2;
  localparam logic [8:0] LONG_HEADER  = 9'd4;
  localparam logic [8:0] SHORT_HEADER = 9'd1;

  // Result record packs into 54 bits of tdata, padded to 56.
  localparam int TDATA_W = 56;

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_LEN1   = 7'b0000010,
    PH_LEN2   = 7'b0000100,
    PH_START2 = 7'b0001000,
    PH_BODY   = 7'b0010000,
    PH_CHECK  = 7'b0100000,
    PH_STOP   = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_MISMATCH = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_STOP     = 3'd4,
    ERR_TRUNC    = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    FK_ACK    = 2'd0,
    FK_SHORT  = 2'd1,
    FK_LONG   = 2'd2,
    FK_REJECT = 2'd3
  } fkind_t;

  localparam logic ITEM_DATA  = 1'b0;
  localparam logic ITEM_FRAME = 1'b1;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_octet;
    fkind_t     frame_kind;
    err_t       error_code;
    logic [7:0] control_field;
    logic [7:0] address_field;
    logic [7:0] ci_field;
    logic [7:0] user_data_count;
    logic [8:0] frame_octets;
  } res_t;

  function automatic res_t mk_reject(input err_t err, input logic [8:0] octets);
    res_t r;
    r              = '0;
    r.item_kind    = ITEM_FRAME;
    r.frame_kind   = FK_REJECT;
    r.error_code   = err;
    r.frame_octets = octets;
    return r;
  endfunction

endpackage

// File: rtl/mfd_input_reg.sv
// Input register of the M-Bus frame deframer: captures one received octet
// and its end marker. Depends on nothing.
module mfd_input_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  assign s_tready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      held_byte <= s_tdata;
      held_last <= s_tlast;
    end
  end

endmodule

// File: rtl/mfd_parser.sv
// Frame parser of the M-Bus frame deframer: phase, length, count, checksum
// and header state, plus the per-octet result logic. Uses mfd_pkg.
module mfd_parser
  import mfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  output logic       res_valid,
  output res_t       res
);

  phase_t     phase, phase_next;
  logic [7:0] length_field, length_field_next;
  logic [8:0] octet_count, octet_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_control, held_control_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_ci, held_ci_next;
  logic       frame_is_long, frame_is_long_next;

  logic [8:0] idx;
  logic [8:0] count_inc;
  logic       open_frame;

  assign idx       = octet_count - (frame_is_long ? LONG_HEADER : SHORT_HEADER);
  assign count_inc = octet_count + 9'd1;

  always_comb begin
    phase_next         = phase;
    length_field_next  = length_field;
    octet_count_next   = octet_count;
    running_sum_next   = running_sum;
    held_control_next  = held_control;
    held_address_next  = held_address;
    held_ci_next       = held_ci;
    frame_is_long_next = frame_is_long;
    res_valid          = 1'b0;
    res                = '0;
    open_frame         = 1'b0;

    unique case (phase)
      PH_HUNT: begin
        if (rx_byte == OCT_ACK) begin
          res_valid        = 1'b1;
          res.item_kind    = ITEM_FRAME;
          res.frame_kind   = FK_ACK;
          res.frame_octets = 9'd1;
        end else if (rx_byte == OCT_SHORT || rx_byte == OCT_LONG) begin
          frame_is_long_next = (rx_byte == OCT_LONG);
          octet_count_next   = 9'd1;
          running_sum_next   = '0;
          held_control_next  = '0;
          held_address_next  = '0;
          held_ci_next       = '0;
          length_field_next  = (rx_byte == OCT_LONG) ? 8'd0 : SHORT_LENGTH;
          phase_next         = (rx_byte == OCT_LONG) ? PH_LEN1 : PH_BODY;
          open_frame         = 1'b1;
        end
      end
      PH_LEN1: begin
        octet_count_next = count_inc;
        if (rx_byte < MIN_LENGTH) begin
          res_valid  = 1'b1;
          res        = mk_reject(ERR_LENGTH, count_inc);
          phase_next = PH_HUNT;
        end else begin
          length_field_next = rx_byte;
          phase_next        = PH_LEN2;
          open_frame        = 1'b1;
        end
      end
      PH_LEN2: begin
        octet_count_next = count_inc;
        if (rx_byte != length_field) begin
          res_valid  = 1'b1;
          res        = mk_reject(ERR_MISMATCH, count_inc);
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_START2;
          open_frame = 1'b1;
        end
      end
      PH_START2: begin
        octet_count_next = count_inc;
        if (rx_byte != OCT_LONG) begin
          res_valid  = 1'b1;
          res        = mk_reject(ERR_MISMATCH, count_inc);
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_BODY;
          open_frame = 1'b1;
        end
      end
      PH_BODY: begin
        octet_count_next = count_inc;
        running_sum_next = running_sum + rx_byte;
        if (idx == 9'd0) begin
          held_control_next = rx_byte;
        end else if (idx == 9'd1) begin
          held_address_next = rx_byte;
        end else if (idx == 9'd2) begin
          held_ci_next = rx_byte;
        end else begin
          res_valid      = 1'b1;
          res.item_kind  = ITEM_DATA;
          res.data_octet = rx_byte;
        end
        if ((idx + 9'd1) >= {1'b0, length_field}) begin
          phase_next = PH_CHECK;
        end
        open_frame = 1'b1;
      end
      PH_CHECK: begin
        octet_count_next = count_inc;
        running_sum_next = running_sum - rx_byte;
        phase_next       = PH_STOP;
        open_frame       = 1'b1;
      end
      PH_STOP: begin
        octet_count_next = count_inc;
        phase_next       = PH_HUNT;
        res_valid        = 1'b1;
        if (rx_byte != OCT_STOP) begin
          res = mk_reject(ERR_STOP, count_inc);
        end else if (running_sum != 8'd0) begin
          res = mk_reject(ERR_CHECKSUM, count_inc);
        end else begin
          res.item_kind     = ITEM_FRAME;
          res.frame_kind    = frame_is_long ? FK_LONG : FK_SHORT;
          res.control_field = held_control;
          res.address_field = held_address;
          res.ci_field      = frame_is_long ? held_ci : 8'd0;
          res.user_data_count = frame_is_long ? (length_field - MIN_LENGTH) : 8'd0;
          res.frame_octets  = count_inc;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    // Truncation overrides a provisional item when the stream ends mid-frame.
    if (open_frame && buffer_end) begin
      res_valid  = 1'b1;
      res        = mk_reject(ERR_TRUNC, octet_count_next);
      phase_next = PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      length_field  <= '0;
      octet_count   <= '0;
      running_sum   <= '0;
      held_control  <= '0;
      held_address  <= '0;
      held_ci       <= '0;
      frame_is_long <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      length_field  <= length_field_next;
      octet_count   <= octet_count_next;
      running_sum   <= running_sum_next;
      held_control  <= held_control_next;
      held_address  <= held_address_next;
      held_ci       <= held_ci_next;
      frame_is_long <= frame_is_long_next;
    end
  end

endmodule

// File: rtl/mfd_output_reg.sv
// Output register of the M-Bus frame deframer: holds one result request
// until the sink takes it and packs it onto tdata/tuser. Uses mfd_pkg.
module mfd_output_reg
  import mfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  res_t               res,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser
);

  res_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tuser = held.item_kind;
  assign m_tdata = {2'b00,
                    held.frame_octets,
                    held.user_data_count,
                    held.ci_field,
                    held.address_field,
                    held.control_field,
                    held.error_code,
                    held.frame_kind,
                    held.data_octet};

endmodule

// File: rtl/mbus_frame_deframer_core.sv
// Top level of the M-Bus frame deframer: input register, frame parser and
// output register. Uses mfd_pkg, mfd_input_reg, mfd_parser, mfd_output_reg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: rx_byte; s_tlast: buffer_end
//  m_*     | out | m_tvalid/m_tready  | m_tdata: result fields; m_tuser: item_kind
//
// One octet per cycle sustained while the output is not stalled; an octet's result
// shows on m_* after the input register, then parser logic into the output register.
// Octets that yield no result retire from the input register without touching m_*.
// The input stage stalls only while its octet waits on a full, unaccepted output
// register; s_tready then follows m_tready combinationally.
// rst is synchronous, active high: both registers empty, parser back to hunting.
module mbus_frame_deframer_core
  import mfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] rx_byte
  input  logic               s_tlast,   // buffer_end
  output logic               m_tvalid,
  input  logic               m_tready,
  // [7:0] data_octet, [9:8] frame_kind, [12:10] error_code, [20:13] control_field,
  // [28:21] address_field, [36:29] ci_field, [44:37] user_data_count,
  // [53:45] frame_octets, [55:54] zero
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tuser    // item_kind
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       advance;
  logic       res_valid;
  res_t       res;

  // Retire the held octet whenever the output register can take a result.
  assign advance = held_valid && (!m_tvalid || m_tready);

  mfd_input_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  mfd_parser u_parse (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .rx_byte    (held_byte),
    .buffer_end (held_last),
    .res_valid  (res_valid),
    .res        (res)
  );

  mfd_output_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/mfd_checker.sv
// Port-level checks for the M-Bus frame deframer, bound to the top level.
// Uses mfd_pkg.
module mfd_port_assert
  import mfd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [7:0]         s_tdata,
  input logic               s_tlast,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tuser
);

  // Empty output after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A provisional data item carries nothing but its octet.
  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ITEM_DATA) |-> m_tdata[TDATA_W-1:8] == '0)
    else $error("data item with frame fields set");

  // Rejected frames carry an error code, accepted ones never do.
  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ITEM_FRAME) |->
      ((m_tdata[9:8] == FK_REJECT) == (m_tdata[12:10] != ERR_NONE)))
    else $error("error code does not match frame kind");

  // An acknowledge occupies exactly one octet.
  a_ack_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ITEM_FRAME) && (m_tdata[9:8] == FK_ACK) |->
      m_tdata[53:45] == 9'd1)
    else $error("acknowledge with wrong octet count");

endmodule

bind mbus_frame_deframer_core mfd_port_assert u_chk (.*);
